### rtl/core/bmsi_pkg.sv
package bmsi_pkg;

  typedef enum logic [1:0] {
    FUNC_CPU_READ  = 2'd0,
    FUNC_CPU_WRITE = 2'd1,
    FUNC_PPU       = 2'd2,
    FUNC_NONE      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_PRG_RAM = 2'd1,
    TGT_PRG_ROM = 2'd2,
    TGT_CHR     = 2'd3
  } target_t;

  // one bus access as held in the input register
  typedef struct packed {
    func_t       func;
    logic [15:0] address;
    logic [7:0]  data;
    logic [8:0]  ppu_cycle;
  } acc_t;

  // mapper register decode
  localparam logic [15:0] REG_DEC_MASK    = 16'h6001;
  localparam logic [15:0] REG_BANK_SELECT = 16'h0000;
  localparam logic [15:0] REG_BANK_DATA   = 16'h0001;
  localparam logic [15:0] REG_MIRROR      = 16'h2000;
  localparam logic [15:0] REG_IRQ_PERIOD  = 16'h4000;
  localparam logic [15:0] REG_IRQ_RELOAD  = 16'h4001;
  localparam logic [15:0] REG_IRQ_DISABLE = 16'h6000;
  localparam logic [15:0] REG_IRQ_ENABLE  = 16'h6001;

  localparam logic [15:0] PRG_RAM_BASE = 16'h6000;
  localparam logic [15:0] PRG_ROM_BASE = 16'h8000;
  localparam logic [15:0] CHR_LIMIT    = 16'h1FFF;

  // configuration register indexes
  localparam logic [1:0] CFG_PRG_BANK_COUNT   = 2'd0;
  localparam logic [1:0] CFG_NT_LOCK          = 2'd1;
  localparam logic [1:0] CFG_INITIAL_VERTICAL = 2'd2;

  localparam logic [7:0] PRG_BANK_COUNT_RST = 8'd32;

  localparam logic [1:0] NT_QUAD = 2'd2;

  // a12 filter
  localparam logic [3:0]  A12_MIN_LOW  = 4'd9;
  localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

  localparam logic [2:0] BANK_R6 = 3'd6;
  localparam logic [2:0] BANK_R7 = 3'd7;

endpackage

### rtl/core/bmsi_bank.sv
module bmsi_bank (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  bmsi_pkg::acc_t   acc,
  input  logic [7:0]       prg_bank_count,
  input  logic             nt_lock,
  input  logic             cfg_init_wr,
  input  logic             cfg_init_val,
  output bmsi_pkg::target_t target,
  output logic [21:0]      maddr,
  output logic             mirror_nxt
);
  import bmsi_pkg::*;

  logic [7:0]  bank_regs_r [8];
  logic [2:0]  bank_index_r, bank_index_nxt;
  logic        prg_swap_r, prg_swap_nxt;
  logic        chr_inv_r, chr_inv_nxt;
  logic        mirror_r;
  logic        reg_wr;
  logic        bank_wr;
  logic [15:0] dec;
  logic [1:0]  win;
  logic        use_last;
  logic [2:0]  prg_idx;
  logic [2:0]  chr_idx;
  logic [2:0]  rd_idx;
  logic [7:0]  rd;
  logic [7:0]  nm1;
  logic [12:0] chr_a;
  logic [17:0] chr_addr;
  logic        is_cpu;

  assign reg_wr = fire && (acc.func == FUNC_CPU_WRITE) && acc.address[15];
  assign dec    = acc.address & REG_DEC_MASK;

  always_comb begin
    bank_index_nxt = bank_index_r;
    prg_swap_nxt   = prg_swap_r;
    chr_inv_nxt    = chr_inv_r;
    mirror_nxt     = mirror_r;
    bank_wr        = 1'b0;
    if (cfg_init_wr) begin
      mirror_nxt = cfg_init_val;
    end else if (reg_wr) begin
      case (dec)
        REG_BANK_SELECT: begin
          bank_index_nxt = acc.data[2:0];
          prg_swap_nxt   = acc.data[6];
          chr_inv_nxt    = acc.data[7];
        end
        REG_BANK_DATA: bank_wr = 1'b1;
        REG_MIRROR: begin
          if (!nt_lock) mirror_nxt = acc.data[0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_index_r <= 3'd0;
      prg_swap_r   <= 1'b0;
      chr_inv_r    <= 1'b0;
      mirror_r     <= 1'b0;
    end else begin
      bank_index_r <= bank_index_nxt;
      prg_swap_r   <= prg_swap_nxt;
      chr_inv_r    <= chr_inv_nxt;
      mirror_r     <= mirror_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (bank_wr) bank_regs_r[bank_index_r] <= acc.data;
  end

  // program windows: 8 KiB each, two switchable and two fixed near the end
  assign win = acc.address[14:13];
  always_comb begin
    use_last = 1'b0;
    prg_idx  = BANK_R6;
    case (win)
      2'd0: begin
        use_last = prg_swap_r;
        prg_idx  = BANK_R6;
      end
      2'd1: prg_idx = BANK_R7;
      2'd2: begin
        use_last = !prg_swap_r;
        prg_idx  = BANK_R6;
      end
      default: use_last = 1'b1;
    endcase
  end

  assign chr_a   = {acc.address[12] ^ chr_inv_r, acc.address[11:0]};
  assign chr_idx = chr_a[12] ? (3'd2 + {1'b0, chr_a[11:10]}) : {2'b00, chr_a[11]};
  assign rd_idx  = (acc.func == FUNC_PPU) ? chr_idx : prg_idx;
  assign rd      = bank_regs_r[rd_idx];

  // 1 KiB pages in the upper half, 2 KiB pages in the lower half
  assign chr_addr = chr_a[12] ? {rd, chr_a[9:0]} : {rd[7:1], chr_a[10:0]};

  assign nm1    = (prg_bank_count == 8'd0) ? 8'd0 : prg_bank_count - 8'd1;
  assign is_cpu = (acc.func == FUNC_CPU_READ) || (acc.func == FUNC_CPU_WRITE);

  always_comb begin
    target = TGT_NONE;
    maddr  = 22'd0;
    if (is_cpu) begin
      if (acc.address >= PRG_ROM_BASE) begin
        if (acc.func == FUNC_CPU_READ) begin
          target = TGT_PRG_ROM;
          maddr  = use_last ? {nm1, win[0], acc.address[12:0]}
                            : {3'd0, rd[5:0], acc.address[12:0]};
        end
      end else if (acc.address >= PRG_RAM_BASE) begin
        target = TGT_PRG_RAM;
        maddr  = {9'd0, acc.address[12:0]};
      end
    end else if (acc.func == FUNC_PPU && acc.address <= CHR_LIMIT) begin
      target = TGT_CHR;
      maddr  = {4'd0, chr_addr};
    end
  end

endmodule

### rtl/core/bmsi_irq.sv
module bmsi_irq #(
  parameter int DOTS_PER_LINE = 341
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  bmsi_pkg::acc_t acc,
  output logic           flag_nxt
);
  import bmsi_pkg::*;

  localparam int StepW = $clog2(DOTS_PER_LINE + 512);

  logic [7:0]       period_r, period_nxt;
  logic [7:0]       count_r, count_nxt;
  logic             enable_r, enable_nxt;
  logic             reload_r, reload_nxt;
  logic             flag_r;
  logic             last_a12_r, last_a12_nxt;
  logic [8:0]       last_dot_r, last_dot_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;
  logic             a12;
  logic [7:0]       clk_val;
  logic             clk_hit;
  logic             fwd;
  logic [StepW-1:0] wrap_sum;
  logic [StepW-1:0] step;
  logic [16:0]      elapsed_sum;
  logic [3:0]       threshold;
  logic [1:0]       phase_adv;

  assign a12 = acc.address[12];

  // counter clock: reload on pending or zero, otherwise count down
  assign clk_val = (reload_r || count_r == 8'd0) ? period_r : count_r - 8'd1;
  assign clk_hit = (count_r != 8'd0 || reload_r) && clk_val == 8'd0 && enable_r;

  assign fwd      = acc.ppu_cycle >= last_dot_r;
  assign wrap_sum = StepW'(DOTS_PER_LINE) + StepW'(acc.ppu_cycle);
  always_comb begin
    if (fwd) step = StepW'(acc.ppu_cycle - last_dot_r);
    else if (wrap_sum >= StepW'(last_dot_r)) step = wrap_sum - StepW'(last_dot_r);
    else step = '0;
  end
  assign elapsed_sum = {1'b0, elapsed_r} + 17'(step);
  assign threshold   = A12_MIN_LOW + {2'b00, phase_r};

  // phase advances by two, modulo three
  always_comb begin
    case (phase_r)
      2'd0:    phase_adv = 2'd2;
      2'd1:    phase_adv = 2'd0;
      2'd2:    phase_adv = 2'd1;
      default: phase_adv = 2'd2;
    endcase
  end

  always_comb begin
    period_nxt   = period_r;
    count_nxt    = count_r;
    enable_nxt   = enable_r;
    reload_nxt   = reload_r;
    flag_nxt     = flag_r;
    last_a12_nxt = last_a12_r;
    last_dot_nxt = last_dot_r;
    phase_nxt    = phase_r;
    elapsed_nxt  = elapsed_r;
    if (fire && acc.func == FUNC_CPU_WRITE && acc.address[15]) begin
      case (acc.address & REG_DEC_MASK)
        REG_IRQ_PERIOD: period_nxt = acc.data;
        REG_IRQ_RELOAD: reload_nxt = 1'b1;
        REG_IRQ_DISABLE: begin
          enable_nxt = 1'b0;
          flag_nxt   = 1'b0;
        end
        REG_IRQ_ENABLE: enable_nxt = 1'b1;
        default: ;
      endcase
    end else if (fire && acc.func == FUNC_PPU) begin
      if (!last_a12_r && a12) begin
        if (elapsed_r >= {12'd0, threshold}) begin
          count_nxt  = clk_val;
          reload_nxt = 1'b0;
          if (clk_hit) flag_nxt = 1'b1;
        end
      end else if (last_a12_r && !a12) begin
        elapsed_nxt = 16'd1;
      end else if (!a12) begin
        elapsed_nxt = elapsed_sum[16] ? ELAPSED_MAX : elapsed_sum[15:0];
      end
      if (fwd) phase_nxt = phase_adv;
      last_dot_nxt = acc.ppu_cycle;
      last_a12_nxt = a12;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= 8'd0;
      count_r    <= 8'd0;
      enable_r   <= 1'b0;
      reload_r   <= 1'b0;
      flag_r     <= 1'b0;
      last_a12_r <= 1'b0;
      last_dot_r <= 9'd0;
      phase_r    <= 2'd0;
      elapsed_r  <= 16'd0;
    end else begin
      period_r   <= period_nxt;
      count_r    <= count_nxt;
      enable_r   <= enable_nxt;
      reload_r   <= reload_nxt;
      flag_r     <= flag_nxt;
      last_a12_r <= last_a12_nxt;
      last_dot_r <= last_dot_nxt;
      phase_r    <= phase_nxt;
      elapsed_r  <= elapsed_nxt;
    end
  end

endmodule

### rtl/core/bank_mapper_scanline_irq_top.sv
// Cartridge bank mapper with a scanline interrupt counter. Every bus access
// (CPU read, CPU write or PPU access) yields one result: the memory that
// answers it, the byte address in that memory, the interrupt line level and
// the nametable mode after the access. The block takes one access per clock
// while out_stall does not hold the pipeline; an access passes through an
// input register and its result is then registered in the output register.
// Mapping, register decode and the A12 filter are all combinational logic
// between those two registers. Bank data registers are not reset: map
// through a bank only after writing it. Configuration writes are taken at
// any time (cfg_ready is always high) but belong in idle time.
module bank_mapper_scanline_irq_top #(
  parameter int DOTS_PER_LINE = 341
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [8:0]  in_ppu_cycle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_target,
  output logic [21:0] out_mapped_address,
  output logic        out_irq_active,
  output logic [1:0]  out_nametable_mode,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import bmsi_pkg::*;

  logic        s1_valid_r;
  acc_t        s1_acc_r;
  logic        s1_stall;
  logic        fire;
  logic        in_accept;
  logic        out_valid_r;
  logic [1:0]  out_target_r;
  logic [21:0] out_maddr_r;
  logic        out_irq_r;
  logic [1:0]  out_nt_r;
  logic [7:0]  prg_bank_count_r;
  logic        nt_lock_r;
  logic        cfg_wr;
  logic        cfg_init_wr;
  target_t     target;
  logic [21:0] maddr;
  logic        mirror_nxt;
  logic        flag_nxt;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign cfg_init_wr = cfg_wr && (cfg_index == CFG_INITIAL_VERTICAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_count_r <= PRG_BANK_COUNT_RST;
      nt_lock_r        <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_PRG_BANK_COUNT: prg_bank_count_r <= cfg_data;
        CFG_NT_LOCK:        nt_lock_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // two-stage pipeline with a common stall
  assign s1_stall  = out_valid_r && out_stall;
  assign in_stall  = s1_valid_r && s1_stall;
  assign in_accept = in_valid && !in_stall;
  assign fire      = s1_valid_r && !s1_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_acc_r.func      <= func_t'(in_func);
      s1_acc_r.address   <= in_address;
      s1_acc_r.data      <= in_data;
      s1_acc_r.ppu_cycle <= in_ppu_cycle;
    end
  end

  bmsi_bank u_bank (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .acc            (s1_acc_r),
    .prg_bank_count (prg_bank_count_r),
    .nt_lock        (nt_lock_r),
    .cfg_init_wr    (cfg_init_wr),
    .cfg_init_val   (cfg_data[0]),
    .target         (target),
    .maddr          (maddr),
    .mirror_nxt     (mirror_nxt)
  );

  bmsi_irq #(
    .DOTS_PER_LINE (DOTS_PER_LINE)
  ) u_irq (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .acc      (s1_acc_r),
    .flag_nxt (flag_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!s1_stall) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_target_r <= target;
      out_maddr_r  <= maddr;
      out_irq_r    <= flag_nxt;
      out_nt_r     <= nt_lock_r ? NT_QUAD : {1'b0, mirror_nxt};
    end
  end

  assign out_valid          = out_valid_r;
  assign out_target         = out_target_r;
  assign out_mapped_address = out_maddr_r;
  assign out_irq_active     = out_irq_r;
  assign out_nametable_mode = out_nt_r;

endmodule
